// ===== sv/ictf_pkg.sv =====
`timescale 1ns / 1ps

package ictf_pkg;

    localparam int MAX_CALIB    = 64;
    localparam int SEEN_W       = $clog2(MAX_CALIB + 1);
    localparam int CORDIC_STEPS = 20;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 56;
    localparam int CNT_W        = $clog2(DIV_STEPS);
    localparam int DEN_W        = 26;
    localparam int CW           = 36;
    localparam int ZW           = 25;
    localparam logic signed [ZW-1:0] DEG90 = 25'sd5898240;

    typedef enum logic [1:0] {
        KIND_CALIB,
        KIND_CALIB_LAST,
        KIND_RUN
    } kind_t;

    typedef enum logic [1:0] {
        REG_CALIB_COUNT  = 2'd0,
        REG_GYRO_DIVISOR = 2'd1,
        REG_BLEND_WEIGHT = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_SUM,
        S_BLEND,
        S_FUSE
    } state_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic [31:0]        timestamp_ms;
    } item_t;

    typedef struct packed {
        logic [31:0]        elapsed_ms;
        logic signed [23:0] tilt_x;
        logic signed [23:0] tilt_y;
        logic signed [31:0] gyro_only_x;
        logic signed [31:0] gyro_only_y;
        logic signed [31:0] gyro_only_z;
        logic signed [31:0] fused_x;
        logic signed [31:0] fused_y;
        logic signed [31:0] fused_z;
    } res_t;

    // Q16.16 degrees of atan(2^-i)
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0:    r = 25'sd2949120;
            5'd1:    r = 25'sd1740967;
            5'd2:    r = 25'sd919879;
            5'd3:    r = 25'sd466945;
            5'd4:    r = 25'sd234379;
            5'd5:    r = 25'sd117304;
            5'd6:    r = 25'sd58666;
            5'd7:    r = 25'sd29335;
            5'd8:    r = 25'sd14668;
            5'd9:    r = 25'sd7334;
            5'd10:   r = 25'sd3667;
            5'd11:   r = 25'sd1833;
            5'd12:   r = 25'sd917;
            5'd13:   r = 25'sd458;
            5'd14:   r = 25'sd229;
            5'd15:   r = 25'sd115;
            5'd16:   r = 25'sd57;
            5'd17:   r = 25'sd29;
            5'd18:   r = 25'sd14;
            5'd19:   r = 25'sd7;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
        logic signed [31:0] r;
        if (v > 58'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -58'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/imu_tilt_complementary_filter.sv =====
`timescale 1ns / 1ps

// Tilt estimator: complementary filter over six-axis IMU samples.
// Input channel (in_valid/in_ready): one beat per sample, three accel axes,
// three gyro axes and a millisecond timestamp. After reset the first beat is
// dropped and the next calib_count beats, clamped to 1..64, build the gyro offsets; none of
// them yields a result. Every later beat yields one result beat.
// Output channel (out_valid/out_ready): elapsed time, accelerometer tilt,
// gyro-only angles and blended angles, all angles Q16.16 degrees.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 calib_count,
// 1 gyro_divisor, 2 blend_weight; other indexes are dropped. Write only when
// idle.
// Each sample runs load, the 56-step shared divide sequence (which also
// hides the 32-step square root and 20-step CORDIC of both tilt lanes), sum,
// blend and fuse; the engine takes the next sample only once it is idle again.
// The last calibration beat runs the same divide to form the offsets.
// A two-beat queue sits in front of the engine; the result register lets the
// engine start the next sample while a result waits. A stalled receiver
// holds only the finished result; the engine waits at its fuse step.
// Reset clears all filter state and loads the register defaults.

module imu_tilt_complementary_filter import ictf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic [31:0]        timestamp_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        elapsed_ms,
    output logic signed [23:0] tilt_x,
    output logic signed [23:0] tilt_y,
    output logic signed [31:0] gyro_only_x,
    output logic signed [31:0] gyro_only_y,
    output logic signed [31:0] gyro_only_z,
    output logic signed [31:0] fused_x,
    output logic signed [31:0] fused_y,
    output logic signed [31:0] fused_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic [6:0]  calib_count_reg;
    logic [15:0] gyro_divisor_reg;
    logic [15:0] blend_weight_reg;

    item_t in_item;
    item_t head_item;
    logic  head_valid;
    logic  head_pop;
    res_t  res;

    assign cfg_ready = 1'b1;

    // register file; unknown indexes drop the beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_count_reg  <= 7'd10;
            gyro_divisor_reg <= 16'd131;
            blend_weight_reg <= 16'd62915;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CALIB_COUNT:  calib_count_reg  <= cfg_data[6:0];
                REG_GYRO_DIVISOR: gyro_divisor_reg <= cfg_data;
                REG_BLEND_WEIGHT: blend_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_item.kind         = KIND_RUN;
        in_item.accel_x      = accel_x;
        in_item.accel_y      = accel_y;
        in_item.accel_z      = accel_z;
        in_item.rate_x       = rate_x;
        in_item.rate_y       = rate_y;
        in_item.rate_z       = rate_z;
        in_item.timestamp_ms = timestamp_ms;
    end

    // front: drop, classify and queue
    ictf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .calib_count (calib_count_reg),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .head_pop    (head_pop)
    );

    // back: calibration, integration, tilt and blend
    ictf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop),
        .gyro_divisor (gyro_divisor_reg),
        .blend_weight (blend_weight_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_res      (res)
    );

    assign elapsed_ms  = res.elapsed_ms;
    assign tilt_x      = res.tilt_x;
    assign tilt_y      = res.tilt_y;
    assign gyro_only_x = res.gyro_only_x;
    assign gyro_only_y = res.gyro_only_y;
    assign gyro_only_z = res.gyro_only_z;
    assign fused_x     = res.fused_x;
    assign fused_y     = res.fused_y;
    assign fused_z     = res.fused_z;

endmodule

// ===== sv/ictf_front.sv =====
`timescale 1ns / 1ps

module ictf_front import ictf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  item_t      in_item,
    input  logic [6:0] calib_count,
    output logic       head_valid,
    output item_t      head_item,
    input  logic       head_pop
);

    logic              first_dropped_reg;
    logic              calibrated_reg;
    logic [SEEN_W-1:0] seen_reg;
    item_t             q_mem_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    logic              accept;
    logic              push;
    logic              last;
    logic [SEEN_W-1:0] eff;
    logic [SEEN_W-1:0] seen_next;
    item_t             push_item;

    assign in_ready   = (count_reg != 2'd2);
    assign accept     = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        if (calib_count == 7'd0)
            eff = SEEN_W'(1);
        else if (calib_count > 7'(MAX_CALIB))
            eff = SEEN_W'(MAX_CALIB);
        else
            eff = SEEN_W'(calib_count);
        seen_next = seen_reg + SEEN_W'(1);
        last      = (seen_next >= eff);
        push      = accept && first_dropped_reg;
        push_item = in_item;
        if (calibrated_reg)
            push_item.kind = KIND_RUN;
        else if (last)
            push_item.kind = KIND_CALIB_LAST;
        else
            push_item.kind = KIND_CALIB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_dropped_reg <= 1'b0;
            calibrated_reg    <= 1'b0;
            seen_reg          <= '0;
            wr_ptr_reg        <= 1'b0;
            rd_ptr_reg        <= 1'b0;
            count_reg         <= 2'd0;
        end
        else
        begin
            // drop the first beat, then count calibration beats
            if (accept && !first_dropped_reg)
                first_dropped_reg <= 1'b1;
            if (push && !calibrated_reg)
            begin
                seen_reg <= seen_next;
                if (last)
                    calibrated_reg <= 1'b1;
            end
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (head_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !head_pop)
                count_reg <= count_reg + 2'd1;
            else if (!push && head_pop)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= push_item;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

    a_calib_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_item.kind == KIND_CALIB_LAST) |=> calibrated_reg)
        else $error("calibration end not recorded");

endmodule

// ===== sv/ictf_back.sv =====
`timescale 1ns / 1ps

module ictf_back import ictf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  item_t       head_item,
    output logic        head_pop,
    input  logic [15:0] gyro_divisor,
    input  logic [15:0] blend_weight,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg;
    logic                     offs_reg;
    item_t                    item_reg;
    logic [31:0]              dt_reg;
    logic [31:0]              prev_time_reg;
    logic [SEEN_W-1:0]        seen_reg;
    logic signed [23:0]       sums_reg      [3];
    logic signed [15:0]       offsets_reg   [3];
    logic signed [31:0]       raw_reg       [3];
    logic signed [31:0]       fused_reg     [3];
    logic signed [31:0]       g_reg         [3];
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg       [3];
    logic [DIV_STEPS-1:0]     num_reg       [3];
    logic                     neg_reg       [3];
    logic [63:0]              rad_reg       [2];
    logic [33:0]              sq_rem_reg    [2];
    logic [31:0]              root_reg      [2];
    logic signed [CW-1:0]     cx_reg        [2];
    logic signed [CW-1:0]     cy_reg        [2];
    logic signed [ZW-1:0]     cz_reg        [2];
    logic                     zero_reg      [2];
    logic signed [16:0]       tnum_reg      [2];
    logic signed [23:0]       tilt_reg      [2];
    logic signed [48:0]       pg_reg        [2];
    logic signed [41:0]       pt_reg        [2];
    logic                     out_valid_reg;
    res_t                     out_res_reg;

    logic                     out_load;
    logic signed [15:0]       head_rate     [3];
    logic signed [23:0]       sums_add      [3];
    logic [26:0]              div_t         [3];
    logic                     div_ge        [3];
    logic [DEN_W-1:0]         rem_step      [3];
    logic [33:0]              sq_t          [2];
    logic [33:0]              sq_trial      [2];
    logic                     sq_ge         [2];
    logic [33:0]              sq_rem_step   [2];
    logic [31:0]              root_step     [2];
    logic [4:0]               ci;
    logic signed [CW-1:0]     cxs           [2];
    logic signed [CW-1:0]     cys           [2];
    logic signed [56:0]       d_w           [3];
    logic signed [31:0]       raw_w         [3];
    logic signed [31:0]       g_w           [3];
    logic signed [23:0]       tilt_w        [2];
    logic signed [31:0]       fuse_w        [2];
    logic signed [15:0]       rate_item     [3];
    logic signed [16:0]       diff_w        [3];
    logic [15:0]              mag_w         [3];
    logic [31:0]              dt_w;
    logic [15:0]              div_eff;
    logic signed [15:0]       tnum_src0;
    logic signed [15:0]       tnum_src1;
    logic signed [15:0]       tnum_src2;
    logic signed [49:0]       acc_w         [2];
    logic [16:0]              wbar;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_item.kind)
                        KIND_RUN:        state_next = S_LOAD;
                        KIND_CALIB_LAST: state_next = S_DIV;
                        default:         state_next = S_IDLE;
                    endcase
                end
            end
            S_LOAD:  state_next = S_DIV;
            S_DIV:   if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_SUM;
            S_SUM:   state_next = offs_reg ? S_IDLE : S_BLEND;
            S_BLEND: state_next = S_FUSE;
            S_FUSE:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        head_pop = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  head_pop = head_valid;
            S_FUSE:  out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // per-step datapath
    always_comb
    begin
        head_rate[0] = head_item.rate_x;
        head_rate[1] = head_item.rate_y;
        head_rate[2] = head_item.rate_z;
        rate_item[0] = item_reg.rate_x;
        rate_item[1] = item_reg.rate_y;
        rate_item[2] = item_reg.rate_z;
        dt_w    = item_reg.timestamp_ms - prev_time_reg;
        div_eff = (gyro_divisor == 16'd0) ? 16'd1 : gyro_divisor;
        wbar    = 17'd65536 - {1'b0, blend_weight};
        ci      = cnt_reg[4:0];
        tnum_src0 = item_reg.accel_y;
        tnum_src1 = item_reg.accel_x;
        tnum_src2 = item_reg.accel_z;
        for (int a = 0; a < 3; a++)
        begin
            sums_add[a] = sums_reg[a] + 24'(head_rate[a]);
            div_t[a]    = {rem_reg[a], num_reg[a][DIV_STEPS-1]};
            div_ge[a]   = (div_t[a] >= {1'b0, den_reg});
            rem_step[a] = div_ge[a] ? DEN_W'(div_t[a] - {1'b0, den_reg})
                                    : div_t[a][DEN_W-1:0];
            diff_w[a]   = 17'(rate_item[a]) - 17'(offsets_reg[a]);
            mag_w[a]    = diff_w[a][16] ? 16'(-diff_w[a]) : diff_w[a][15:0];
            d_w[a]      = neg_reg[a] ? -$signed({1'b0, num_reg[a]})
                                     : $signed({1'b0, num_reg[a]});
            raw_w[a]    = sat32(58'(raw_reg[a]) + 58'(d_w[a]));
            g_w[a]      = sat32(58'(fused_reg[a]) + 58'(d_w[a]));
        end
        for (int l = 0; l < 2; l++)
        begin
            sq_t[l]        = {sq_rem_reg[l][31:0], rad_reg[l][63:62]};
            sq_trial[l]    = {root_reg[l], 2'b01};
            sq_ge[l]       = (sq_t[l] >= sq_trial[l]);
            sq_rem_step[l] = sq_ge[l] ? (sq_t[l] - sq_trial[l]) : sq_t[l];
            root_step[l]   = {root_reg[l][30:0], sq_ge[l]};
            cxs[l]         = cx_reg[l] >>> ci;
            cys[l]         = cy_reg[l] >>> ci;
            // zero root: the sign of the numerator alone picks the angle
            if (zero_reg[l])
            begin
                if (tnum_reg[l] > 17'sd0)
                    tilt_w[l] = DEG90[23:0];
                else if (tnum_reg[l] < 17'sd0)
                    tilt_w[l] = -DEG90[23:0];
                else
                    tilt_w[l] = '0;
            end
            else if (cz_reg[l] > DEG90)
                tilt_w[l] = DEG90[23:0];
            else if (cz_reg[l] < -DEG90)
                tilt_w[l] = -DEG90[23:0];
            else
                tilt_w[l] = cz_reg[l][23:0];
            acc_w[l]  = 50'(pg_reg[l]) + 50'(pt_reg[l]);
            fuse_w[l] = sat32(58'($signed(acc_w[l][49:16])));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            offs_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_time_reg <= '0;
            seen_reg      <= '0;
            for (int a = 0; a < 3; a++)
            begin
                sums_reg[a]    <= '0;
                offsets_reg[a] <= '0;
                raw_reg[a]     <= '0;
                fused_reg[a]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (head_pop && head_item.kind != KIND_RUN)
                    begin
                        // accumulate; on the last beat start the offset divide
                        for (int a = 0; a < 3; a++)
                            sums_reg[a] <= sums_add[a];
                        seen_reg <= seen_reg + SEEN_W'(1);
                        offs_reg <= 1'b1;
                    end
                    else
                        offs_reg <= 1'b0;
                end
                S_LOAD:
                    prev_time_reg <= item_reg.timestamp_ms;
                S_DIV:
                    cnt_reg <= cnt_reg + CNT_W'(1);
                S_SUM:
                begin
                    if (offs_reg)
                    begin
                        for (int a = 0; a < 3; a++)
                            offsets_reg[a] <= d_w[a][15:0];
                        prev_time_reg <= item_reg.timestamp_ms;
                    end
                    else
                    begin
                        for (int a = 0; a < 3; a++)
                            raw_reg[a] <= raw_w[a];
                    end
                end
                S_FUSE:
                begin
                    if (out_load)
                    begin
                        fused_reg[0] <= fuse_w[0];
                        fused_reg[1] <= fuse_w[1];
                        fused_reg[2] <= g_reg[2];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload: divider, square root and CORDIC lanes, products, result
    always_ff @(posedge clk)
    begin
        if (head_pop)
            item_reg <= head_item;

        if (head_pop && head_item.kind == KIND_CALIB_LAST)
        begin
            den_reg <= DEN_W'(seen_reg + SEEN_W'(1));
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= '0;
                neg_reg[a] <= sums_add[a][23];
                num_reg[a] <= DIV_STEPS'(sums_add[a][23] ? 24'(-sums_add[a])
                                                         : sums_add[a]);
            end
        end

        if (state_reg == S_LOAD)
        begin
            dt_reg  <= dt_w;
            den_reg <= DEN_W'(div_eff * 10'd1000);
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= '0;
                neg_reg[a] <= diff_w[a][16];
                num_reg[a] <= {48'(mag_w[a] * dt_w), 8'b0};
            end
            rad_reg[0]  <= {32'(tnum_src1 * tnum_src1) + 32'(tnum_src2 * tnum_src2),
                            32'b0};
            rad_reg[1]  <= {32'(tnum_src0 * tnum_src0) + 32'(tnum_src2 * tnum_src2),
                            32'b0};
            tnum_reg[0] <= 17'(tnum_src0);
            tnum_reg[1] <= -17'(tnum_src1);
            for (int l = 0; l < 2; l++)
            begin
                sq_rem_reg[l] <= '0;
                root_reg[l]   <= '0;
            end
        end

        if (state_reg == S_DIV)
        begin
            for (int a = 0; a < 3; a++)
            begin
                rem_reg[a] <= rem_step[a];
                num_reg[a] <= {num_reg[a][DIV_STEPS-2:0], div_ge[a]};
            end
            for (int l = 0; l < 2; l++)
            begin
                if (cnt_reg < CNT_W'(SQRT_STEPS))
                begin
                    sq_rem_reg[l] <= sq_rem_step[l];
                    root_reg[l]   <= root_step[l];
                    rad_reg[l]    <= {rad_reg[l][61:0], 2'b00};
                    // last root bit: seed the rotation
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        cx_reg[l]   <= CW'({1'b0, root_step[l]});
                        cy_reg[l]   <= CW'($signed({tnum_reg[l], 16'b0}));
                        cz_reg[l]   <= '0;
                        zero_reg[l] <= (root_step[l] == 32'd0);
                    end
                end
                else if (cnt_reg < CNT_W'(SQRT_STEPS + CORDIC_STEPS))
                begin
                    if (!cy_reg[l][CW-1])
                    begin
                        cx_reg[l] <= cx_reg[l] + cys[l];
                        cy_reg[l] <= cy_reg[l] - cxs[l];
                        cz_reg[l] <= cz_reg[l] + atan_q16(ci);
                    end
                    else
                    begin
                        cx_reg[l] <= cx_reg[l] - cys[l];
                        cy_reg[l] <= cy_reg[l] + cxs[l];
                        cz_reg[l] <= cz_reg[l] - atan_q16(ci);
                    end
                end
            end
        end

        if (state_reg == S_SUM)
        begin
            for (int a = 0; a < 3; a++)
                g_reg[a] <= g_w[a];
            tilt_reg[0] <= tilt_w[0];
            tilt_reg[1] <= tilt_w[1];
        end

        if (state_reg == S_BLEND)
        begin
            for (int l = 0; l < 2; l++)
            begin
                pg_reg[l] <= $signed({1'b0, blend_weight}) * g_reg[l];
                pt_reg[l] <= $signed({1'b0, wbar}) * tilt_reg[l];
            end
        end

        if (out_load)
        begin
            out_res_reg.elapsed_ms  <= dt_reg;
            out_res_reg.tilt_x      <= tilt_reg[0];
            out_res_reg.tilt_y      <= tilt_reg[1];
            out_res_reg.gyro_only_x <= raw_reg[0];
            out_res_reg.gyro_only_y <= raw_reg[1];
            out_res_reg.gyro_only_z <= raw_reg[2];
            out_res_reg.fused_x     <= fuse_w[0];
            out_res_reg.fused_y     <= fuse_w[1];
            out_res_reg.fused_z     <= g_reg[2];
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> state_reg == S_IDLE)
        else $error("queue popped while busy");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= CNT_W'(DIV_STEPS - 1))
        else $error("step counter overran");

    a_load_fuse: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && $past(state_reg) == S_FUSE)
        else $error("result loaded outside fuse step");

    a_offs_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && offs_reg) |=> state_reg == S_IDLE)
        else $error("calibration produced a result path");

endmodule

// ===== tb/sv/imu_tilt_complementary_filter_chk.sv =====
`timescale 1ns / 1ps

module imu_tilt_complementary_filter_chk import ictf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] rate_x,
    input  logic signed [15:0] rate_y,
    input  logic signed [15:0] rate_z,
    input  logic [31:0]        timestamp_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [31:0]        elapsed_ms,
    input  logic signed [23:0] tilt_x,
    input  logic signed [23:0] tilt_y,
    input  logic signed [31:0] gyro_only_x,
    input  logic signed [31:0] gyro_only_y,
    input  logic signed [31:0] gyro_only_z,
    input  logic signed [31:0] fused_x,
    input  logic signed [31:0] fused_y,
    input  logic signed [31:0] fused_z,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output int                 fail_count,
    output int                 pending
);

    localparam longint DEG90_L = 5898240;

    logic [6:0]  m_calib_count;
    logic [15:0] m_divisor;
    logic [15:0] m_weight;
    longint      m_sums [3];
    longint      m_offs [3];
    int          m_seen;
    bit          m_dropped;
    bit          m_calibrated;
    logic [31:0] m_prev;
    longint      m_fused [3];
    longint      m_raw [3];

    res_t        angle_queue [$];

    function automatic longint arith_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // atan(num / sqrt(a^2 + b^2)) in Q16.16 degrees
    function automatic longint accel_angle(longint num, longint a, longint b);
        longint tab [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                             58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                             229, 115, 57, 29, 14, 7};
        logic [63:0] s;
        longint x, y, z, xs, ys;
        s = a * a + b * b;
        x = root64(s << 32);
        y = num * 65536;
        z = 0;
        if (x == 0)
            return (y > 0) ? DEG90_L : ((y < 0) ? -DEG90_L : 0);
        for (int i = 0; i < 20; i++)
        begin
            xs = arith_shr(x, i);
            ys = arith_shr(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += tab[i];
            end
            else
            begin
                x -= ys; y += xs; z -= tab[i];
            end
        end
        if (z > DEG90_L) z = DEG90_L;
        if (z < -DEG90_L) z = -DEG90_L;
        return z;
    endfunction

    task automatic absorb_sample();
        longint rt [3];
        longint tl [2];
        longint den, d, g, acc;
        int eff;
        logic [31:0] dt;
        res_t r;
        rt[0] = rate_x; rt[1] = rate_y; rt[2] = rate_z;
        if (!m_dropped)
        begin
            m_dropped = 1'b1;
            return;
        end
        if (!m_calibrated)
        begin
            eff = int'(m_calib_count);
            if (eff < 1) eff = 1;
            if (eff > MAX_CALIB) eff = MAX_CALIB;
            for (int a = 0; a < 3; a++)
                m_sums[a] += rt[a];
            m_seen++;
            if (m_seen >= eff)
            begin
                for (int a = 0; a < 3; a++)
                    m_offs[a] = m_sums[a] / m_seen;
                m_prev = timestamp_ms;
                m_calibrated = 1'b1;
            end
            return;
        end
        dt = timestamp_ms - m_prev;
        m_prev = timestamp_ms;
        den = 1000 * ((m_divisor == 16'd0) ? 64'sd1 : longint'(m_divisor));
        tl[0] = accel_angle(accel_y, accel_x, accel_z);
        tl[1] = accel_angle(-longint'(accel_x), accel_y, accel_z);
        for (int a = 0; a < 3; a++)
        begin
            d = (rt[a] - m_offs[a]) * longint'(dt) * 256 / den;
            g = clip32(m_fused[a] + d);
            m_raw[a] = clip32(m_raw[a] + d);
            if (a < 2)
            begin
                acc = longint'(m_weight) * g + (65536 - longint'(m_weight)) * tl[a];
                m_fused[a] = clip32(acc >>> 16);
            end
            else
                m_fused[a] = g;
        end
        r.elapsed_ms  = dt;
        r.tilt_x      = tl[0][23:0];
        r.tilt_y      = tl[1][23:0];
        r.gyro_only_x = m_raw[0][31:0];
        r.gyro_only_y = m_raw[1][31:0];
        r.gyro_only_z = m_raw[2][31:0];
        r.fused_x     = m_fused[0][31:0];
        r.fused_y     = m_fused[1][31:0];
        r.fused_z     = m_fused[2][31:0];
        angle_queue.push_back(r);
    endtask

    task automatic cmp(string name, longint e, longint a);
        if (e != a)
        begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        if (!rst_n)
        begin
            m_calib_count = 7'd10;
            m_divisor = 16'd131;
            m_weight = 16'd62915;
            for (int a = 0; a < 3; a++)
            begin
                m_sums[a] = 0; m_offs[a] = 0; m_fused[a] = 0; m_raw[a] = 0;
            end
            m_seen = 0;
            m_dropped = 1'b0;
            m_calibrated = 1'b0;
            m_prev = '0;
            angle_queue.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_CALIB_COUNT:  m_calib_count = cfg_data[6:0];
                    REG_GYRO_DIVISOR: m_divisor = cfg_data;
                    REG_BLEND_WEIGHT: m_weight = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = angle_queue.pop_front();
                    cmp("elapsed_ms", e.elapsed_ms, elapsed_ms);
                    cmp("tilt_x", e.tilt_x, tilt_x);
                    cmp("tilt_y", e.tilt_y, tilt_y);
                    cmp("gyro_only_x", e.gyro_only_x, gyro_only_x);
                    cmp("gyro_only_y", e.gyro_only_y, gyro_only_y);
                    cmp("gyro_only_z", e.gyro_only_z, gyro_only_z);
                    cmp("fused_x", e.fused_x, fused_x);
                    cmp("fused_y", e.fused_y, fused_y);
                    cmp("fused_z", e.fused_z, fused_z);
                end
            end
            if (in_valid && in_ready)
                absorb_sample();
            pending = angle_queue.size();
        end
    end

endmodule

// ===== tb/sv/imu_tilt_complementary_filter_tb.sv =====
`timescale 1ns / 1ps

module imu_tilt_complementary_filter_tb import ictf_pkg::*; ;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic signed [15:0] rate_x, rate_y, rate_z;
    logic [31:0]        timestamp_ms;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        elapsed_ms;
    logic signed [23:0] tilt_x, tilt_y;
    logic signed [31:0] gyro_only_x, gyro_only_y, gyro_only_z;
    logic signed [31:0] fused_x, fused_y, fused_z;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    int                 fail_count;
    int                 pending;

    // Running sample clock; advanced by a random step per motion or noise beat.
    logic [31:0]        clock_ms;
    // Disables receiver stalls during the quiet stretch.
    bit                 calm;

    imu_tilt_complementary_filter dut (.*);
    imu_tilt_complementary_filter_chk chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Receiver: stall about 13 beats in a hundred, except when calm.
    always @(negedge clk)
        out_ready <= calm || ($urandom_range(99) >= 13);

    // Drive one sample beat; hold until accepted, with random idle before it.
    // Valid stays high after the beat until the next call or a drain drops it.
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                               logic [31:0] ts);
        while (!calm && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        accel_x      <= ax;
        accel_y      <= ay;
        accel_z      <= az;
        rate_x       <= gx;
        rate_y       <= gy;
        rate_z       <= gz;
        timestamp_ms <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait out every expected result, then the engine's latency.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (150)
            @(negedge clk);
    endtask

    // Random motion: accel within +-mag on each axis, gyro within +-300.
    task automatic send_motion(int mag);
        clock_ms += $urandom_range(20);
        send_sample(16'($urandom_range(2 * mag) - mag), 16'($urandom_range(2 * mag) - mag),
                    16'($urandom_range(2 * mag) - mag), 16'($urandom_range(600) - 300),
                    16'($urandom_range(600) - 300), 16'($urandom_range(600) - 300),
                    clock_ms);
    endtask

    task automatic send_noise();
        clock_ms += $urandom;
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom),
                    ($urandom_range(3) == 0) ? $urandom : clock_ms);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_CALIB_COUNT;
        cfg_data     = '0;
        accel_x      = '0;
        accel_y      = '0;
        accel_z      = '0;
        rate_x       = '0;
        rate_y       = '0;
        rate_z       = '0;
        timestamp_ms = '0;
        clock_ms     = 32'd1000;
        calm         = 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default registers: dropped beat plus ten calibration beats.
        for (int i = 0; i < 11; i++)
            send_motion(300);
        // Directed extremes: field limits, zero root in all three signs.
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'hFFFFFFFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0);
        send_sample(16'h0000, 16'h4000, 16'h0000, 16'h0, 16'h0, 16'h0, 32'h10);
        send_sample(16'h0000, 16'hC000, 16'h0000, 16'h0, 16'h0, 16'h0, 32'h20);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 32'h20);
        send_sample(16'h4000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 32'h30);
        send_sample(16'hC000, 16'h0000, 16'h0000, 16'h0, 16'h0, 16'h0, 32'h40);
        // Long gaps drive integrated angles into saturation.
        send_sample(16'h0, 16'h0, 16'h0100, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hC0000040);
        send_sample(16'h0, 16'h0, 16'h0100, 16'h7FFF, 16'h8000, 16'h7FFF, 32'h80000040);
        send_sample(16'h0, 16'h0, 16'h0100, 16'h8000, 16'h7FFF, 16'h8000, 32'h40000040);
        drain();

        // Register extremes after calibration: no restart.
        write_reg(REG_GYRO_DIVISOR, 16'd0);
        write_reg(REG_BLEND_WEIGHT, 16'd0);
        write_reg(REG_CALIB_COUNT, 16'd1);
        for (int i = 0; i < 4; i++)
            send_noise();
        drain();
        write_reg(REG_GYRO_DIVISOR, 16'hFFFF);
        write_reg(REG_BLEND_WEIGHT, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            send_noise();
        drain();

        // Random phases with varying settings; a quiet stretch in the middle.
        for (int ph = 0; ph < 8; ph++)
        begin
            calm = (ph == 4);
            write_reg(REG_GYRO_DIVISOR,
                      (ph % 3 == 0) ? 16'($urandom) : 16'($urandom_range(50, 300)));
            write_reg(REG_BLEND_WEIGHT, (ph == 5) ? 16'd0 : 16'($urandom));
            write_reg(REG_CALIB_COUNT, 16'($urandom_range(127)));
            for (int i = 0; i < 140; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_noise();
                else
                    send_motion((i % 2) ? 400 : 32767);
            end
            drain();
        end
        calm = 1'b0;

        if (fail_count == 0)
            $display("imu_tilt_complementary_filter_tb: clean");
        else
            $display("imu_tilt_complementary_filter_tb: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("imu_tilt_complementary_filter_tb: errors");
        $finish;
    end

endmodule
